// File: hw/rtl/telemetry_line_value_extractor_unit_assert.svh
`ifndef TELEMETRY_LINE_VALUE_EXTRACTOR_UNIT_ASSERT_SVH
`define TELEMETRY_LINE_VALUE_EXTRACTOR_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define TLVE_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define TLVE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLVE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tlve_pkg.sv
package tlve_pkg;

	localparam int KW_SLOTS = 24;
	localparam int KLEN_W = 5;
	localparam logic [KLEN_W-1:0] KW_LEN_RESET = 5'd24;

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;

	localparam int ACC_W = 19;
	localparam logic [ACC_W-1:0] MAG_LIMIT_POS = 19'd32767;
	localparam logic [ACC_W-1:0] MAG_LIMIT_NEG = 19'd32768;

	// parse phase codes
	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_SIGNED = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_STOPPED = 2'd3;

	// register indexes (byte address / 8)
	localparam logic [1:0] REG_KW_LOW = 2'd0;
	localparam logic [1:0] REG_KW_MID = 2'd1;
	localparam logic [1:0] REG_KW_HIGH = 2'd2;
	localparam logic [1:0] REG_KW_LEN = 2'd3;

	typedef struct packed {
		logic clear;
		logic parse;
		logic stop;
	} parse_ctl_t;

endpackage

// File: hw/rtl/telemetry_line_value_extractor_unit.sv
// Keyword/value line extractor.
// Slave stream (s_axis_*): one text byte per beat; byte 10 ends a line.
// Master stream (m_axis_*): one beat per line that holds the keyword, sent at
// its newline, carrying the signed value after the keyword, a saturation flag
// and a digits-present flag. Lines without the keyword give no beat.
// APB port: 64-bit registers at 0x00/0x08/0x10 (keyword chars 0-7, 8-15,
// 16-23, char 0 lowest byte) and 0x18 (keyword length); pready is tied high.
// Throughput: one byte per cycle unless a result beat is stalled, set by the
// single input register feeding the history compare and the times-ten
// accumulate. The newline passes the input register, then the result register.
// Stall: a pending result holds in the output register; one more byte is
// taken into the input register, then s_axis_tready drops until the result
// is taken.
// Reset: keyword chars clear to zero, length to 24, all line state clears.
// Only the first LINE_MAX-1 bytes of a line are searched and parsed.
module telemetry_line_value_extractor_unit #(
	parameter int LINE_MAX = 64,
	parameter int KEYWORD_MAX = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [15:0] field_value, [16] value_saturated,
	                                   // [17] digits_present, [23:18] zero
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

`include "telemetry_line_value_extractor_unit_assert.svh"

	logic [63:0] kw_low_q;
	logic [63:0] kw_mid_q;
	logic [63:0] kw_high_q;
	logic [tlve_pkg::KLEN_W-1:0] kw_len_q;
	logic [1:0] reg_idx;
	logic cfg_wr;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic process;

	tlve_pkg::parse_ctl_t ctl;
	logic emit;
	logic signed [15:0] value;
	logic sat;
	logic dig;

	logic out_valid_q;
	logic signed [15:0] out_value_q;
	logic out_sat_q;
	logic out_dig_q;

	// configuration
	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_low_q <= '0;
			kw_mid_q <= '0;
			kw_high_q <= '0;
			kw_len_q <= tlve_pkg::KW_LEN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tlve_pkg::REG_KW_LOW: kw_low_q <= pwdata;
				tlve_pkg::REG_KW_MID: kw_mid_q <= pwdata;
				tlve_pkg::REG_KW_HIGH: kw_high_q <= pwdata;
				tlve_pkg::REG_KW_LEN: kw_len_q <= pwdata[tlve_pkg::KLEN_W-1:0];
				default: kw_low_q <= kw_low_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tlve_pkg::REG_KW_LOW: prdata = kw_low_q;
			tlve_pkg::REG_KW_MID: prdata = kw_mid_q;
			tlve_pkg::REG_KW_HIGH: prdata = kw_high_q;
			tlve_pkg::REG_KW_LEN: prdata = 64'(kw_len_q);
			default: prdata = '0;
		endcase
	end

	// input register
	assign process = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	tlve_matcher #(
		.LINE_MAX(LINE_MAX),
		.KEYWORD_MAX(KEYWORD_MAX)
	) u_matcher (
		.clk(clk),
		.arst_n(arst_n),
		.kw_low(kw_low_q),
		.kw_mid(kw_mid_q),
		.kw_high(kw_high_q),
		.kw_len(kw_len_q),
		.step(process),
		.rx_byte(byte_s1),
		.ctl(ctl),
		.emit(emit)
	);

	tlve_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rx_byte(byte_s1),
		.field_value(value),
		.value_saturated(sat),
		.digits_present(dig)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.clear && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear && emit) begin
			out_value_q <= value;
			out_sat_q <= sat;
			out_dig_q <= dig;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'b0, out_dig_q, out_sat_q, out_value_q};

	`TLVE_ASSERT_IMP(a_tready_low_full, !s_axis_tready, valid_s1,
		"input stalled with empty input register")
	`TLVE_ASSERT_IMP(a_no_overwrite, out_valid_q && !m_axis_tready, !process,
		"byte processed while result beat is stalled")
	`TLVE_ASSERT_NXT(a_emit_shows, ctl.clear && emit, out_valid_q,
		"matched line did not raise a result beat")

endmodule

// File: hw/rtl/tlve_matcher.sv
module tlve_matcher #(
	parameter int LINE_MAX = 64,
	parameter int KEYWORD_MAX = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [63:0] kw_low,
	input  logic [63:0] kw_mid,
	input  logic [63:0] kw_high,
	input  logic [tlve_pkg::KLEN_W-1:0] kw_len,
	input  logic step,
	input  logic [7:0] rx_byte,
	output tlve_pkg::parse_ctl_t ctl,
	output logic emit
);

	localparam int LPW = $clog2(LINE_MAX);
	localparam int CW = ((LPW > tlve_pkg::KLEN_W) ? LPW : tlve_pkg::KLEN_W) + 1;
	localparam logic [tlve_pkg::KLEN_W-1:0] KMAX = tlve_pkg::KLEN_W'(KEYWORD_MAX);

	logic [7:0] key_c [tlve_pkg::KW_SLOTS];
	logic [tlve_pkg::KLEN_W-1:0] klen_c;
	logic [tlve_pkg::KLEN_W-1:0] klen_q;
	logic [7:0] key_al_c [KEYWORD_MAX];
	logic [7:0] key_al_q [KEYWORD_MAX];
	logic [7:0] hist_q [KEYWORD_MAX];
	logic [7:0] nh [KEYWORD_MAX];
	logic [LPW-1:0] line_pos_q;
	logic [LPW-1:0] pos_next;
	logic found_q;
	logic cut_q;
	logic is_nl;
	logic is_nul;
	logic full;
	logic found_eff;
	logic hit;
	logic len_ok;

	for (genvar i = 0; i < tlve_pkg::KW_SLOTS; i++) begin : g_key
		if (i < 8) begin : g_lo
			assign key_c[i] = kw_low[(i%8)*8 +: 8];
		end else if (i < 16) begin : g_mid
			assign key_c[i] = kw_mid[(i%8)*8 +: 8];
		end else begin : g_hi
			assign key_c[i] = kw_high[(i%8)*8 +: 8];
		end
	end

	// effective length: clamp, then stop at first zero char
	always_comb begin
		logic [tlve_pkg::KLEN_W-1:0] n;
		n = (kw_len > KMAX) ? KMAX : kw_len;
		klen_c = n;
		for (int i = tlve_pkg::KW_SLOTS - 1; i >= 0; i--) begin
			if (tlve_pkg::KLEN_W'(i) < n && key_c[i] == tlve_pkg::CH_NUL) begin
				klen_c = tlve_pkg::KLEN_W'(i);
			end
		end
	end

	// key reversed so slot j lines up with history tap j
	always_comb begin
		for (int j = 0; j < KEYWORD_MAX; j++) begin
			if (tlve_pkg::KLEN_W'(j) < klen_c) begin
				key_al_c[j] = key_c[klen_c - tlve_pkg::KLEN_W'(j) - tlve_pkg::KLEN_W'(1)];
			end else begin
				key_al_c[j] = tlve_pkg::CH_NUL;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_al_q <= key_al_c;
	end

	always_comb begin
		nh[0] = rx_byte;
		for (int j = 1; j < KEYWORD_MAX; j++) begin
			nh[j] = hist_q[j-1];
		end
	end

	always_comb begin
		hit = 1'b1;
		for (int j = 0; j < KEYWORD_MAX; j++) begin
			if (tlve_pkg::KLEN_W'(j) < klen_q && nh[j] != key_al_q[j]) begin
				hit = 1'b0;
			end
		end
	end

	assign is_nl = (rx_byte == tlve_pkg::CH_NEWLINE);
	assign is_nul = (rx_byte == tlve_pkg::CH_NUL);
	assign full = (line_pos_q == LPW'(LINE_MAX - 1));
	assign pos_next = line_pos_q + LPW'(1);
	assign len_ok = (CW'(pos_next) >= CW'(klen_q));
	assign found_eff = found_q || (klen_q == '0);

	assign ctl.clear = step && is_nl;
	assign ctl.parse = step && !is_nl && !full && found_eff;
	assign ctl.stop = is_nul;
	assign emit = found_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			line_pos_q <= '0;
			found_q <= 1'b0;
			cut_q <= 1'b0;
			for (int j = 0; j < KEYWORD_MAX; j++) hist_q[j] <= '0;
		end else begin
			klen_q <= klen_c;
			if (step) begin
				if (is_nl) begin
					line_pos_q <= '0;
					found_q <= 1'b0;
					cut_q <= 1'b0;
					for (int j = 0; j < KEYWORD_MAX; j++) hist_q[j] <= '0;
				end else if (!full) begin
					line_pos_q <= pos_next;
					cut_q <= cut_q || is_nul;
					if (found_eff) begin
						found_q <= 1'b1;
					end else begin
						hist_q <= nh;
						if (!(cut_q || is_nul) && len_ok && hit) found_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: hw/rtl/tlve_parser.sv
module tlve_parser (
	input  logic clk,
	input  logic arst_n,
	input  tlve_pkg::parse_ctl_t ctl,
	input  logic [7:0] rx_byte,
	output logic signed [15:0] field_value,
	output logic value_saturated,
	output logic digits_present
);

`include "telemetry_line_value_extractor_unit_assert.svh"

	logic [1:0] phase_q;
	logic neg_q;
	logic [15:0] mag_q;
	logic ovf_q;
	logic dig_q;
	logic is_digit;
	logic is_space;
	logic is_sign;
	logic [tlve_pkg::ACC_W-1:0] limit;
	logic [tlve_pkg::ACC_W-1:0] acc;
	logic over;

	assign is_digit = (rx_byte >= tlve_pkg::CH_ZERO) && (rx_byte <= tlve_pkg::CH_NINE);
	assign is_space = (rx_byte == tlve_pkg::CH_SPACE) ||
		((rx_byte >= tlve_pkg::CH_TAB) && (rx_byte <= tlve_pkg::CH_CR));
	assign is_sign = (rx_byte == tlve_pkg::CH_PLUS) || (rx_byte == tlve_pkg::CH_MINUS);
	assign limit = neg_q ? tlve_pkg::MAG_LIMIT_NEG : tlve_pkg::MAG_LIMIT_POS;
	assign acc = tlve_pkg::ACC_W'(mag_q) * tlve_pkg::ACC_W'(10) +
		tlve_pkg::ACC_W'(rx_byte[3:0]);
	assign over = (acc > limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlve_pkg::PH_SKIP;
			neg_q <= 1'b0;
			mag_q <= '0;
			ovf_q <= 1'b0;
			dig_q <= 1'b0;
		end else if (ctl.clear) begin
			phase_q <= tlve_pkg::PH_SKIP;
			neg_q <= 1'b0;
			mag_q <= '0;
			ovf_q <= 1'b0;
			dig_q <= 1'b0;
		end else if (ctl.parse) begin
			if (ctl.stop) begin
				phase_q <= tlve_pkg::PH_STOPPED;
			end else if (phase_q != tlve_pkg::PH_STOPPED) begin
				if (is_digit) begin
					mag_q <= over ? limit[15:0] : acc[15:0];
					ovf_q <= ovf_q || over;
					dig_q <= 1'b1;
					phase_q <= tlve_pkg::PH_DIGITS;
				end else if (phase_q == tlve_pkg::PH_SKIP && is_space) begin
					phase_q <= tlve_pkg::PH_SKIP;
				end else if (phase_q == tlve_pkg::PH_SKIP && is_sign) begin
					neg_q <= (rx_byte == tlve_pkg::CH_MINUS);
					phase_q <= tlve_pkg::PH_SIGNED;
				end else begin
					phase_q <= tlve_pkg::PH_STOPPED;
				end
			end
		end
	end

	assign field_value = neg_q ? $signed(16'h0000 - mag_q) : $signed(mag_q);
	assign value_saturated = ovf_q;
	assign digits_present = dig_q;

	`TLVE_ASSERT_NOW(a_mag_range, mag_q <= 16'd32768, "magnitude above negative limit")
	`TLVE_ASSERT_IMP(a_pos_range, !neg_q, mag_q <= 16'd32767, "positive magnitude above limit")
	`TLVE_ASSERT_IMP(a_skip_clean, phase_q == tlve_pkg::PH_SKIP, !dig_q && !neg_q,
		"digit or sign recorded while still skipping whitespace")

endmodule

// File: test/tb_telemetry_line_value_extractor_unit.sv
`timescale 1ns / 1ps

module tb_telemetry_line_value_extractor_unit;

	localparam int LINE_MAX = 64;
	localparam int KEYWORD_MAX = 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [15:0] value;
		logic saturated;
		logic has_digits;
	} line_value_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = 5'd0;
	logic [63:0] pwdata = 64'd0;
	logic [63:0] prdata;
	logic pready;

	telemetry_line_value_extractor_unit #(
		.LINE_MAX(LINE_MAX),
		.KEYWORD_MAX(KEYWORD_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// line parser shadow state
	logic [63:0] kw_words [3];
	logic [4:0] kw_len;
	logic [7:0] recent [KEYWORD_MAX];
	int line_pos;
	int unsigned magnitude;
	bit kw_found;
	bit negative;
	bit clamped;
	bit got_digit;
	bit text_cut;
	logic [1:0] phase;

	line_value_t expected_values [$];

	int mismatch_count = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	function automatic logic [7:0] kw_char(int i);
		return kw_words[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic int kw_active_len();
		int n;
		n = int'(kw_len);
		if (n > KEYWORD_MAX) n = KEYWORD_MAX;
		for (int i = 0; i < n; i++)
			if (kw_char(i) == tlve_pkg::CH_NUL) return i;
		return n;
	endfunction

	function automatic void clear_line_state();
		foreach (recent[i]) recent[i] = tlve_pkg::CH_NUL;
		line_pos = 0;
		kw_found = 0;
		phase = tlve_pkg::PH_SKIP;
		negative = 0;
		magnitude = 0;
		clamped = 0;
		got_digit = 0;
		text_cut = 0;
	endfunction

	function automatic void parse_char(logic [7:0] c);
		bit digit;
		bit space;
		int unsigned lim;
		int unsigned m;
		digit = (c >= tlve_pkg::CH_ZERO) && (c <= tlve_pkg::CH_NINE);
		space = (c == tlve_pkg::CH_SPACE) || ((c >= tlve_pkg::CH_TAB) && (c <= tlve_pkg::CH_CR));
		if (phase == tlve_pkg::PH_STOPPED) return;
		if (digit) begin
			lim = negative ? 32'(tlve_pkg::MAG_LIMIT_NEG) : 32'(tlve_pkg::MAG_LIMIT_POS);
			m = magnitude * 10 + (32'(c) - 32'(tlve_pkg::CH_ZERO));
			if (m > lim) begin
				m = lim;
				clamped = 1;
			end
			magnitude = m;
			got_digit = 1;
			phase = tlve_pkg::PH_DIGITS;
		end else if (phase == tlve_pkg::PH_SKIP && space) begin
		end else if (phase == tlve_pkg::PH_SKIP &&
				(c == tlve_pkg::CH_PLUS || c == tlve_pkg::CH_MINUS)) begin
			negative = (c == tlve_pkg::CH_MINUS);
			phase = tlve_pkg::PH_SIGNED;
		end else begin
			phase = tlve_pkg::PH_STOPPED;
		end
	endfunction

	function automatic void track_rx_byte(logic [7:0] c);
		int len;
		bit match;
		line_value_t r;
		len = kw_active_len();
		if (c == tlve_pkg::CH_NEWLINE) begin
			if (kw_found || len == 0) begin
				r.value = negative ? 16'(32'h10000 - magnitude) : 16'(magnitude);
				r.saturated = clamped;
				r.has_digits = got_digit;
				expected_values.push_back(r);
			end
			clear_line_state();
			return;
		end
		if (line_pos >= LINE_MAX - 1) return;
		line_pos++;
		if (!kw_found && len == 0) kw_found = 1;
		if (kw_found) begin
			if (c == tlve_pkg::CH_NUL) begin
				text_cut = 1;
				phase = tlve_pkg::PH_STOPPED;
			end else begin
				parse_char(c);
			end
			return;
		end
		if (c == tlve_pkg::CH_NUL) text_cut = 1;
		for (int i = KEYWORD_MAX - 1; i > 0; i--) recent[i] = recent[i - 1];
		recent[0] = c;
		if (!text_cut && line_pos >= len) begin
			match = 1;
			for (int i = 0; i < len; i++)
				if (recent[len - 1 - i] != kw_char(i)) match = 0;
			if (match) kw_found = 1;
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		line_value_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_values.size() == 0) begin
				report_mismatch("beat with no line pending", int'(m_axis_tdata), 0);
			end else begin
				want = expected_values.pop_front();
				if (m_axis_tdata[15:0] !== want.value)
					report_mismatch("field_value", int'(m_axis_tdata[15:0]),
						int'(want.value));
				if (m_axis_tdata[16] !== want.saturated)
					report_mismatch("value_saturated", int'(m_axis_tdata[16]),
						int'(want.saturated));
				if (m_axis_tdata[17] !== want.has_digits)
					report_mismatch("digits_present", int'(m_axis_tdata[17]),
						int'(want.has_digits));
				if (m_axis_tdata[23:18] !== 6'd0)
					report_mismatch("pad bits", int'(m_axis_tdata[23:18]), 0);
			end
			results_seen++;
		end
	end

	// receiver: random stalls plus requested long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_byte(logic [7:0] c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		do @(posedge clk); while (!s_axis_tready);
		track_rx_byte(c);
		bytes_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_repeat(logic [7:0] c, int n);
		repeat (n) send_byte(c);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			tlve_pkg::REG_KW_LOW: kw_words[0] = value;
			tlve_pkg::REG_KW_MID: kw_words[1] = value;
			tlve_pkg::REG_KW_HIGH: kw_words[2] = value;
			tlve_pkg::REG_KW_LEN: kw_len = value[4:0];
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_keyword(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
			logic [4:0] len);
		wait_drained();
		apb_write(tlve_pkg::REG_KW_LOW, lo);
		apb_write(tlve_pkg::REG_KW_MID, mid);
		apb_write(tlve_pkg::REG_KW_HIGH, hi);
		apb_write(tlve_pkg::REG_KW_LEN, {59'd0, len});
	endtask

	task automatic set_keyword_text(string s, int len);
		logic [63:0] w [3];
		foreach (w[i]) w[i] = 64'd0;
		for (int i = 0; i < s.len() && i < KEYWORD_MAX; i++) w[i / 8][(i % 8) * 8 +: 8] = s[i];
		write_keyword(w[0], w[1], w[2], len[4:0]);
	endtask

	task automatic random_keyword();
		logic [63:0] w [3];
		int len;
		int mode;
		int used;
		foreach (w[i]) w[i] = {$urandom, $urandom};
		mode = $urandom_range(9);
		case (mode)
			0: len = 0;
			1: len = KEYWORD_MAX;
			2: len = $urandom_range(25, 31);
			3: len = 1;
			default: len = $urandom_range(2, 8);
		endcase
		used = (len > KEYWORD_MAX) ? KEYWORD_MAX : len;
		if ($urandom_range(2) != 0)
			for (int i = 0; i < used; i++)
				w[i / 8][(i % 8) * 8 +: 8] = 8'($urandom_range(65, 90));
		if (mode == 4) begin
			used = $urandom_range(1, used - 1);
			w[used / 8][(used % 8) * 8 +: 8] = tlve_pkg::CH_NUL;
		end
		write_keyword(w[0], w[1], w[2], len[4:0]);
	endtask

	function automatic logic [7:0] random_text_char();
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] random_space();
		case ($urandom_range(4))
			0: return tlve_pkg::CH_TAB;
			1: return 8'd11;
			2: return 8'd12;
			3: return tlve_pkg::CH_CR;
			default: return tlve_pkg::CH_SPACE;
		endcase
	endfunction

	task automatic send_digits(int n);
		repeat (n) send_byte(tlve_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_random_line();
		int kind;
		int klen;
		int pos;
		kind = $urandom_range(99);
		klen = kw_active_len();
		if (kind < 70) begin
			repeat ($urandom_range(0, 6)) send_byte(random_text_char());
			for (int i = 0; i < klen; i++) send_byte(kw_char(i));
			repeat ($urandom_range(0, 2)) send_byte(random_space());
			case ($urandom_range(3))
				0: send_byte(tlve_pkg::CH_PLUS);
				1: send_byte(tlve_pkg::CH_MINUS);
				default: ;
			endcase
			send_digits(($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5));
			repeat ($urandom_range(0, 4)) send_byte(random_text_char());
		end else if (kind < 85) begin
			repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)));
		end else if (kind < 93) begin
			repeat ($urandom_range(50, 75)) send_byte(random_text_char());
			for (int i = 0; i < klen; i++) send_byte(kw_char(i));
			send_digits(3);
		end else begin
			// keyword with one character damaged or cut by a zero byte
			pos = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
			for (int i = 0; i < klen; i++)
				if (i == pos) send_byte($urandom_range(1) ? tlve_pkg::CH_NUL : random_text_char());
				else send_byte(kw_char(i));
			send_digits($urandom_range(1, 4));
		end
		send_byte(tlve_pkg::CH_NEWLINE);
	endtask

	task automatic test_reset_defaults();
		send_text("12\n");
		send_text("x\n");
	endtask

	task automatic test_value_parsing();
		set_keyword_text("V", 1);
		send_text("V \t7\n");
		send_text("V-32768\n");
		send_text("V32768\n");
		send_text("V-99999\n");
		send_text("V+\n");
		send_text("xyz\n");
		send_text("V");
		send_byte(tlve_pkg::CH_NUL);
		send_text("5\n");
		send_byte(tlve_pkg::CH_NUL);
		send_text("V5\n");
		send_text("aV12b3\n");
		send_text("V 1 2\n");
		send_text("\n");
		send_text("V--5\n");
		send_text("VV7\n");
		send_text("V");
		send_byte(8'd11);
		send_byte(8'd12);
		send_byte(tlve_pkg::CH_CR);
		send_text("+00042\n");
		send_text("V\n");
	endtask

	task automatic test_keyword_length_rules();
		// zero character cuts the keyword to "AB"
		write_keyword(64'h0000_0044_4300_4241, 64'd0, 64'd0, 5'd5);
		send_text("AB9\n");
		send_text("ABCD9\n");
		set_keyword_text("abcdefghijklmnopqrstuvwx", 31);
		send_text("abcdefghijklmnopqrstuvwx-12\n");
		send_text("abcdefghijklmnopqrstuvw5\n");
		set_keyword_text("abc", 0);
		send_text(" -17\n");
		send_text("\n");
		write_keyword('1, '1, '1, 5'd24);
		send_repeat(8'hFF, 24);
		send_text("321\n");
	endtask

	task automatic test_long_lines();
		set_keyword_text("V", 1);
		send_repeat("a", 70);
		send_text("V5\n");
		send_repeat("a", 62);
		send_text("V5\n");
		send_text("V");
		send_repeat("9", 70);
		send_text("\n");
	endtask

	task automatic test_output_backpressure();
		set_keyword_text("rpm=", 4);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_request = HOLD_OFF_CYCLES;
		repeat (8) send_text("rpm= 1234\n");
		send_text("rpm=-5");
		wait_drained();
		send_text("6\n");
	endtask

	task automatic test_random_traffic(int send_pct, int stall_pct, int n_bytes);
		int stop;
		sender_idle_pct = send_pct;
		receiver_stall_pct = stall_pct;
		repeat (2) begin
			random_keyword();
			stop = bytes_sent + n_bytes / 2;
			while (bytes_sent < stop) send_random_line();
		end
	endtask

	initial begin
		kw_words[0] = 64'd0;
		kw_words[1] = 64'd0;
		kw_words[2] = 64'd0;
		kw_len = tlve_pkg::KW_LEN_RESET;
		clear_line_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_value_parsing();
		test_keyword_length_rules();
		test_long_lines();
		test_output_backpressure();
		test_random_traffic(0, 0, 220);
		test_random_traffic(81, 0, 220);
		test_random_traffic(0, 81, 220);
		test_random_traffic(30, 30, 220);
		wait_drained();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
